/* rtl/pmsf_pkg.sv */
package pmsf_pkg;

    localparam int CFG_BITS             = 16;
    localparam int CFG_INDEX_BITS       = 1;
    localparam int ENC_BITS             = 32;
    localparam int RPM_BITS             = 41;
    localparam int SCALE_BITS           = 9;
    localparam int DEFAULT_COUNTER_BITS = 16;
    localparam int QUEUE_DEPTH          = 2;
    localparam int DIV_CNT_BITS         = $clog2(RPM_BITS + 1);

    localparam logic [CFG_BITS-1:0]   PERIOD_RESET = 16'd100;
    localparam logic [CFG_BITS-1:0]   ON_RESET     = 16'd50;
    // counts per rev 2048, tick 5 ms, 60 s/min, x64: 60*64/(2048*0.005) = 375
    localparam logic [SCALE_BITS-1:0] RPM_SCALE    = 9'd375;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_PERIOD = 1'b0,
        CFG_ON     = 1'b1
    } cfg_index_t;

    typedef enum logic [2:0] {
        PH_LOW   = 3'd0,
        PH_HIGH  = 3'd1,
        PH_SPEED = 3'd2,
        PH_STOP  = 3'd3,
        PH_EXIT  = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MUL,
        BK_DIV,
        BK_DONE
    } bstate_t;

    typedef struct packed {
        logic                run;
        logic                halted;
        logic                measure;
        logic [ENC_BITS-1:0] enc;
    } task_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    // zero period acts as one
    function automatic logic [CFG_BITS-1:0] eff_period(input logic [CFG_BITS-1:0] p);
        return (p == '0) ? CFG_BITS'(1) : p;
    endfunction

endpackage

/* rtl/pmsf_ifs.sv */
interface pmsf_in_if import pmsf_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [ENC_BITS-1:0] encoder_count;
    logic                stop_pressed;
    logic                print_pressed;

    modport source (output valid, encoder_count, stop_pressed, print_pressed, input ready);
    modport sink   (input valid, encoder_count, stop_pressed, print_pressed, output ready);
endinterface

interface pmsf_out_if import pmsf_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                run_level;
    logic                speed_valid;
    logic [ENC_BITS-1:0] count_delta;
    logic [RPM_BITS-1:0] rpm_x64;
    logic                halted;

    modport source (output valid, run_level, speed_valid, count_delta, rpm_x64, halted,
                    input ready);
    modport sink   (input valid, run_level, speed_valid, count_delta, rpm_x64, halted,
                    output ready);
endinterface

/* rtl/pmsf_queue.sv */
module pmsf_queue import pmsf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  task_t   wdata,
    input  logic    pop,
    output task_t   rdata,
    output q_stat_t stat
);

    localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    task_t               entry_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg;
    logic [CNT_BITS-1:0] count_next;

    assign stat.full  = (count_reg == CNT_BITS'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign rdata      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && stat.full && !pop))
        else $error("queue push while full");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_BITS'(QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule

/* rtl/pmsf_front.sv */
module pmsf_front import pmsf_pkg::*;
#(
    parameter int COUNTER_BITS = DEFAULT_COUNTER_BITS
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [CFG_BITS-1:0] period,
    input  logic [CFG_BITS-1:0] on_time,
    pmsf_in_if.sink             item,
    input  q_stat_t             qstat,
    output logic                push,
    output task_t               entry
);

    localparam int CMP_BITS = (COUNTER_BITS > CFG_BITS) ? COUNTER_BITS : CFG_BITS;

    phase_t                  phase_reg;
    phase_t                  phase_next;
    logic [COUNTER_BITS-1:0] tick_reg;
    logic [COUNTER_BITS-1:0] tick_next;
    logic                    run_reg;
    logic                    run_next;

    logic                    accept;
    logic [CFG_BITS-1:0]     n;
    logic [CFG_BITS-1:0]     n_m1;
    logic [CFG_BITS-1:0]     m;
    logic [CMP_BITS-1:0]     tick_ext;

    assign item.ready = !qstat.full;
    assign accept     = item.valid && !qstat.full;
    assign n          = eff_period(period);
    assign n_m1       = n - 1'b1;
    assign m          = (on_time < n_m1) ? on_time : n_m1;
    assign tick_ext   = CMP_BITS'(tick_reg);

    always_comb
    begin
        logic [COUNTER_BITS-1:0] tick_base;
        phase_next = phase_reg;
        run_next   = run_reg;
        tick_base  = tick_reg;
        tick_next  = tick_reg;
        if (accept)
        begin
            case (phase_reg)
                PH_LOW:
                begin
                    if (tick_ext >= CMP_BITS'(n))
                    begin
                        tick_base = '0;
                        if (item.stop_pressed)
                        begin
                            phase_next = PH_STOP;
                            run_next   = 1'b0;
                        end
                        else if (item.print_pressed)
                        begin
                            phase_next = PH_SPEED;
                            run_next   = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_HIGH;
                            run_next   = 1'b1;
                        end
                    end
                end
                PH_HIGH:
                begin
                    if (tick_ext >= CMP_BITS'(m))
                    begin
                        run_next   = 1'b0;
                        phase_next = PH_LOW;
                    end
                end
                PH_SPEED:
                begin
                    phase_next = PH_HIGH;
                end
                PH_STOP:
                begin
                    run_next   = 1'b0;
                    phase_next = PH_EXIT;
                end
                default:
                begin
                    run_next = 1'b0;
                end
            endcase
            if ((phase_reg == PH_LOW || phase_reg == PH_HIGH || phase_reg == PH_SPEED)
                && phase_next != PH_STOP)
            begin
                tick_next = tick_base + 1'b1;
            end
            else
            begin
                tick_next = tick_base;
            end
        end
    end

    always_comb
    begin
        push          = accept;
        entry.run     = run_next;
        entry.halted  = (phase_next == PH_STOP) || (phase_next == PH_EXIT);
        entry.measure = (phase_reg == PH_SPEED);
        entry.enc     = item.encoder_count;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LOW;
            tick_reg  <= '0;
            run_reg   <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            run_reg   <= run_next;
        end
    end

    a_halt_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_EXIT) |=> (phase_reg == PH_EXIT && $stable(tick_reg) && !run_reg))
        else $error("halted block changed state");

endmodule

/* rtl/pmsf_back.sv */
module pmsf_back import pmsf_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [CFG_BITS-1:0] period,
    input  task_t               entry,
    input  q_stat_t             qstat,
    output logic                pop,
    pmsf_out_if.source          result
);

    bstate_t                 state_reg;
    bstate_t                 state_next;
    logic                    cur_run_reg;
    logic                    cur_halted_reg;
    logic [ENC_BITS-1:0]     last_enc_reg;
    logic                    sampled_reg;
    logic [ENC_BITS-1:0]     delta_reg;
    logic [CFG_BITS-1:0]     n_reg;
    logic [RPM_BITS-1:0]     acc_reg;
    logic [CFG_BITS:0]       rem_reg;
    logic [DIV_CNT_BITS-1:0] cnt_reg;

    logic                    res_valid_reg;
    logic                    res_run_reg;
    logic                    res_speed_reg;
    logic [ENC_BITS-1:0]     res_delta_reg;
    logic [RPM_BITS-1:0]     res_rpm_reg;
    logic                    res_halted_reg;

    logic                    out_free;
    logic                    load_plain;
    logic                    load_meas;
    logic [ENC_BITS-1:0]     delta_new;
    logic [RPM_BITS-1:0]     product;
    logic [CFG_BITS:0]       rem_sh;
    logic                    fits;
    logic [CFG_BITS:0]       rem_new;

    assign out_free  = !res_valid_reg || result.ready;
    assign delta_new = sampled_reg ? entry.enc - last_enc_reg : '0;
    assign product   = RPM_BITS'(delta_reg) * RPM_BITS'(RPM_SCALE);
    assign rem_sh    = {rem_reg[CFG_BITS-1:0], acc_reg[RPM_BITS-1]};
    assign fits      = rem_sh >= {1'b0, n_reg};
    assign rem_new   = fits ? rem_sh - {1'b0, n_reg} : rem_sh;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (!qstat.empty && out_free && entry.measure)
                begin
                    state_next = BK_MUL;
                end
            end
            BK_MUL:
            begin
                state_next = BK_DIV;
            end
            BK_DIV:
            begin
                if (cnt_reg == DIV_CNT_BITS'(1))
                begin
                    state_next = BK_DONE;
                end
            end
            BK_DONE:
            begin
                state_next = BK_IDLE;
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop        = (state_reg == BK_IDLE) && !qstat.empty && out_free;
        load_plain = pop && !entry.measure;
        load_meas  = (state_reg == BK_DONE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            res_valid_reg <= 1'b0;
            sampled_reg   <= 1'b0;
            last_enc_reg  <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_plain || load_meas)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
            if (pop && entry.measure)
            begin
                last_enc_reg <= entry.enc;
                sampled_reg  <= 1'b1;
            end
            if (state_reg == BK_MUL)
            begin
                cnt_reg <= DIV_CNT_BITS'(RPM_BITS);
            end
            else if (state_reg == BK_DIV)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_run_reg    <= entry.run;
            cur_halted_reg <= entry.halted;
            delta_reg      <= delta_new;
            n_reg          <= eff_period(period);
        end
        if (state_reg == BK_MUL)
        begin
            acc_reg <= product;
            rem_reg <= '0;
        end
        else if (state_reg == BK_DIV)
        begin
            acc_reg <= {acc_reg[RPM_BITS-2:0], fits};
            rem_reg <= rem_new;
        end
        if (load_plain)
        begin
            res_run_reg    <= entry.run;
            res_speed_reg  <= 1'b0;
            res_delta_reg  <= '0;
            res_rpm_reg    <= '0;
            res_halted_reg <= entry.halted;
        end
        else if (load_meas)
        begin
            res_run_reg    <= cur_run_reg;
            res_speed_reg  <= 1'b1;
            res_delta_reg  <= delta_reg;
            res_rpm_reg    <= acc_reg;
            res_halted_reg <= cur_halted_reg;
        end
    end

    assign result.valid       = res_valid_reg;
    assign result.run_level   = res_run_reg;
    assign result.speed_valid = res_speed_reg;
    assign result.count_delta = res_delta_reg;
    assign result.rpm_x64     = res_rpm_reg;
    assign result.halted      = res_halted_reg;

    a_done_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_DONE) |-> !res_valid_reg)
        else $error("measurement would overwrite pending result");

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_DIV) |-> (cnt_reg != '0))
        else $error("divider step count exhausted");

    a_speed_sampled: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_speed_reg) |-> sampled_reg)
        else $error("measurement without encoder sample");

endmodule

/* rtl/pwm_motor_speed_fsm.sv */
// A plain tick passes through the queue and then the result register; a speed
// tick passes through the queue, the product, 41 restoring divide steps and the
// result load. The front takes one tick per cycle while the 2-entry queue is not
// full; the back takes no new tick while the bit-serial divider works on a measurement.
// Reset (rst_n, async low): low phase, counter 0, run state low, no sample,
// period 100, on time 50, queue and result register empty.
module pwm_motor_speed_fsm import pmsf_pkg::*;
#(
    parameter int COUNTER_BITS = DEFAULT_COUNTER_BITS
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    pmsf_in_if.sink                   item,
    pmsf_out_if.source                result,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]       cfg_wdata
);

    logic [CFG_BITS-1:0] period_reg;
    logic [CFG_BITS-1:0] on_reg;

    logic    push;
    logic    pop;
    task_t   wr_entry;
    task_t   rd_entry;
    q_stat_t qstat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PERIOD_RESET;
            on_reg     <= ON_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_PERIOD: period_reg <= cfg_wdata;
                CFG_ON:     on_reg     <= cfg_wdata;
                default:    ;
            endcase
        end
    end

    pmsf_front #(
        .COUNTER_BITS(COUNTER_BITS)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .period (period_reg),
        .on_time(on_reg),
        .item   (item),
        .qstat  (qstat),
        .push   (push),
        .entry  (wr_entry)
    );

    pmsf_queue u_queue (
        .clk  (clk),
        .rst_n(rst_n),
        .push (push),
        .wdata(wr_entry),
        .pop  (pop),
        .rdata(rd_entry),
        .stat (qstat)
    );

    pmsf_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .period(period_reg),
        .entry (rd_entry),
        .qstat (qstat),
        .pop   (pop),
        .result(result)
    );

endmodule
